// File: rtl/connected_component_labeler_core_macros.svh
// ----------------------------------------------------------------------------
// Connected component labeler assertion macros
// Shared concurrent assertion wrappers; they expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CONNECTED_COMPONENT_LABELER_CORE_MACROS_SVH
`define CONNECTED_COMPONENT_LABELER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Expression must hold at every clock edge outside reset
`define CCL_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("ccl assertion failed");
// Antecedent implies consequent in the same cycle
`define CCL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ccl implication failed");
// Antecedent implies consequent in the next cycle
`define CCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ccl sequence failed");
`else
`define CCL_ASSERT(lbl, expr)
`define CCL_ASSERT_IMPL(lbl, ante, cons)
`define CCL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// Connected component labeler package
// Field widths, request and status codes, and default sizing.
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int WORD_W           = 64;
    localparam int FUNC_W           = 2;
    localparam int VERTEX_W         = 8;
    localparam int STATUS_W         = 2;
    localparam int LABEL_W          = 8;
    localparam int NUM_VERT_W       = 9;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [NUM_VERT_W-1:0] NUM_VERT_RESET = 9'd256;
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_VERT  = 3'd0;

    // request functions
    localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_LABEL = 2'd2;

endpackage

// File: rtl/ccl_stream_if.sv
// ----------------------------------------------------------------------------
// Connected component labeler stream interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ccl_req_if;
    logic                         valid;
    logic                         ready;
    logic [ccl_pkg::FUNC_W-1:0]   func;
    logic [ccl_pkg::VERTEX_W-1:0] vertex_a;
    logic [ccl_pkg::VERTEX_W-1:0] vertex_b;

    modport source (output valid, func, vertex_a, vertex_b, input ready);
    modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

interface ccl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ccl_pkg::STATUS_W-1:0] status;
    logic [ccl_pkg::LABEL_W-1:0]  component_id;
    logic                         labelled;

    modport source (output valid, status, component_id, labelled, input ready);
    modport sink   (input valid, status, component_id, labelled, output ready);
endinterface

// File: rtl/connected_component_labeler_core.sv
// ----------------------------------------------------------------------------
// Connected component labeler core
// Adjacency bit matrix with depth-first component labeling, held in RAMs.
// ----------------------------------------------------------------------------
// One request at a time; the next request is taken once the result has been
// taken. Add edge is a read-modify-write of one 64-bit adjacency word, a
// query reads the visited word and the label, and an out-of-range request is
// answered straight from the idle state. A run first clears the visited words,
// then for each vertex reached pops it, scans its adjacency row one 64-bit word
// at a time, labels and pushes each newly reached vertex, and before each new
// component rescans the visited words from word 0 for the next start. After
// reset and after each clear request a clearing pass sweeps all
// MAX_VERTICES*ceil(MAX_VERTICES/64) words of the adjacency RAM (1024 at 256
// vertices) and the visited RAM; no request is accepted meanwhile,
// configuration writes are.

`include "connected_component_labeler_core_macros.svh"

module connected_component_labeler_core #(
    parameter int MAX_VERTICES = ccl_pkg::DEF_MAX_VERTICES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ccl_req_if.sink                           i_in,
    ccl_rsp_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ccl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ccl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int WW   = ccl_pkg::WORD_W;
    localparam int RW   = (MAX_VERTICES + WW - 1) / WW;
    localparam int AD   = MAX_VERTICES * RW;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int WIW  = (RW > 1) ? $clog2(RW) : 1;
    localparam int ADW  = $clog2(AD);
    localparam int CLRW = $clog2(AD + 1);
    localparam int BW   = $clog2(WW);
    localparam int LW   = ccl_pkg::LABEL_W;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_EDGE  = 13'b0000000000100,
        S_QRY   = 13'b0000000001000,
        S_VCLR  = 13'b0000000010000,
        S_MARK  = 13'b0000000100000,
        S_DRAIN = 13'b0000001000000,
        S_POP   = 13'b0000010000000,
        S_POPW  = 13'b0000100000000,
        S_ARD   = 13'b0001000000000,
        S_ACHK  = 13'b0010000000000,
        S_SRD   = 13'b0100000000000,
        S_SCHK  = 13'b1000000000000
    } t_state;

    // registers
    t_state                          r_state, n_state;
    logic [CLRW-1:0]                 r_clr_cnt, n_clr_cnt;
    logic                            r_clr_out, n_clr_out;
    logic [ccl_pkg::NUM_VERT_W-1:0]  r_nv;
    logic [ccl_pkg::FUNC_W-1:0]      r_func, n_func;
    logic [ccl_pkg::VERTEX_W-1:0]    r_a, n_a;
    logic [ccl_pkg::VERTEX_W-1:0]    r_b, n_b;
    logic [VW-1:0]                   r_v, n_v;
    logic [WIW-1:0]                  r_w, n_w;
    logic [WIW-1:0]                  r_nbase, n_nbase;
    logic [WW-1:0]                   r_new, n_new;
    logic [CW-1:0]                   r_sp, n_sp;
    logic [CW-1:0]                   r_id, n_id;
    logic                            r_ovalid, n_ovalid;
    logic [ccl_pkg::STATUS_W-1:0]    r_ostatus, n_ostatus;
    logic [LW-1:0]                   r_ocid, n_ocid;
    logic                            r_olab, n_olab;

    // memory ports
    logic           adj_we;
    logic [ADW-1:0] adj_waddr, adj_raddr;
    logic [WW-1:0]  adj_wdata, adj_rdata;
    logic           vis_we;
    logic [WIW-1:0] vis_waddr, vis_raddr;
    logic [WW-1:0]  vis_wdata, vis_rdata;
    logic           lab_we;
    logic [VW-1:0]  lab_waddr, lab_raddr;
    logic [LW-1:0]  lab_wdata, lab_rdata;
    logic           stk_we;
    logic [VW-1:0]  stk_waddr, stk_raddr;
    logic [VW-1:0]  stk_wdata, stk_rdata;

    // combinational helpers
    logic [CW-1:0]  nv_eff;
    logic           a_oor, b_oor;
    logic [WW-1:0]  word_mask;
    logic [BW-1:0]  low_idx;
    logic [WW-1:0]  cand;
    logic [VW-1:0]  drain_v;
    logic           last_word;
    logic           in_acc;
    int             lim;

    ccl_ram #(.WIDTH(WW), .DEPTH(AD)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    ccl_ram #(.WIDTH(WW), .DEPTH(RW)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );
    ccl_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_lab (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rdata)
    );
    ccl_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ccl_pkg::ADDR_NUM_VERT)
                  ? ccl_pkg::APB_DATA_W'(r_nv) : '0;

    // active vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_nv == '0) begin
            nv_eff = CW'(1);
        end else if (32'(r_nv) > MAX_VERTICES) begin
            nv_eff = CW'(MAX_VERTICES);
        end else begin
            nv_eff = CW'(r_nv);
        end
    end

    assign a_oor = 32'(i_in.vertex_a) >= 32'(nv_eff);
    assign b_oor = 32'(i_in.vertex_b) >= 32'(nv_eff);

    // active bits of word r_w
    always_comb begin
        lim = int'(nv_eff) - int'(r_w) * WW;
        if (lim >= WW) begin
            word_mask = '1;
        end else if (lim <= 0) begin
            word_mask = '0;
        end else begin
            word_mask = (WW'(1) << lim) - WW'(1);
        end
    end

    // lowest pending vertex in r_new
    always_comb begin
        low_idx = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (r_new[i]) begin
                low_idx = BW'(i);
            end
        end
    end

    assign drain_v   = VW'(int'(r_nbase) * WW + int'(low_idx));
    assign last_word = 32'(r_w) == RW - 1;
    assign in_acc    = i_in.valid && i_in.ready;

    assign i_in.ready         = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ostatus;
    assign o_out.component_id = r_ocid;
    assign o_out.labelled     = r_olab;

    // main sequencer
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_clr_out = r_clr_out;
        n_func    = r_func;
        n_a       = r_a;
        n_b       = r_b;
        n_v       = r_v;
        n_w       = r_w;
        n_nbase   = r_nbase;
        n_new     = r_new;
        n_sp      = r_sp;
        n_id      = r_id;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ostatus = r_ostatus;
        n_ocid    = r_ocid;
        n_olab    = r_olab;
        adj_we    = 1'b0;
        adj_waddr = '0;
        adj_wdata = '0;
        adj_raddr = '0;
        vis_we    = 1'b0;
        vis_waddr = '0;
        vis_wdata = '0;
        vis_raddr = '0;
        lab_we    = 1'b0;
        lab_waddr = '0;
        lab_wdata = '0;
        lab_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;
        cand      = '0;

        unique case (r_state)
            // sweep adjacency and visited RAMs to zero
            S_CLR: begin
                adj_we    = 1'b1;
                adj_waddr = ADW'(r_clr_cnt);
                if (32'(r_clr_cnt) < RW) begin
                    vis_we    = 1'b1;
                    vis_waddr = WIW'(r_clr_cnt);
                end
                n_clr_cnt = r_clr_cnt + CLRW'(1);
                if (32'(r_clr_cnt) == AD - 1) begin
                    n_state = S_IDLE;
                    if (r_clr_out) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = ccl_pkg::ST_OK;
                        n_ocid    = '0;
                        n_olab    = 1'b0;
                    end
                end
            end

            // take a request
            S_IDLE: begin
                if (in_acc) begin
                    n_func = i_in.func;
                    n_a    = i_in.vertex_a;
                    n_b    = i_in.vertex_b;
                    unique case (i_in.func)
                        ccl_pkg::FUNC_ADD_EDGE: begin
                            adj_raddr = ADW'(32'(i_in.vertex_a) * RW
                                           + (32'(i_in.vertex_b) >> BW));
                            if (a_oor || b_oor) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ccl_pkg::ST_RANGE;
                                n_ocid    = '0;
                                n_olab    = 1'b0;
                            end else begin
                                n_state = S_EDGE;
                            end
                        end
                        ccl_pkg::FUNC_RUN: begin
                            if (a_oor) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ccl_pkg::ST_RANGE;
                                n_ocid    = '0;
                                n_olab    = 1'b0;
                            end else begin
                                n_clr_cnt = '0;
                                n_sp      = '0;
                                n_id      = '0;
                                n_state   = S_VCLR;
                            end
                        end
                        ccl_pkg::FUNC_QUERY: begin
                            vis_raddr = WIW'(32'(i_in.vertex_a) >> BW);
                            lab_raddr = VW'(i_in.vertex_a);
                            if (a_oor) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ccl_pkg::ST_RANGE;
                                n_ocid    = '0;
                                n_olab    = 1'b0;
                            end else begin
                                n_state = S_QRY;
                            end
                        end
                        ccl_pkg::FUNC_CLEAR: begin
                            n_clr_cnt = '0;
                            n_clr_out = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // set the edge bit in the fetched word
            S_EDGE: begin
                adj_we    = 1'b1;
                adj_waddr = ADW'(32'(r_a) * RW + (32'(r_b) >> BW));
                adj_wdata = adj_rdata | (WW'(1) << r_b[BW-1:0]);
                n_ovalid  = 1'b1;
                n_ostatus = ccl_pkg::ST_OK;
                n_ocid    = '0;
                n_olab    = 1'b0;
                n_state   = S_IDLE;
            end

            // query result from visited word and label
            S_QRY: begin
                n_ovalid = 1'b1;
                if (vis_rdata[r_a[BW-1:0]]) begin
                    n_ostatus = ccl_pkg::ST_OK;
                    n_ocid    = lab_rdata;
                    n_olab    = 1'b1;
                end else begin
                    n_ostatus = ccl_pkg::ST_NOT_LABEL;
                    n_ocid    = '0;
                    n_olab    = 1'b0;
                end
                n_state = S_IDLE;
            end

            // clear visited words before a run
            S_VCLR: begin
                vis_we    = 1'b1;
                vis_waddr = WIW'(r_clr_cnt);
                n_clr_cnt = r_clr_cnt + CLRW'(1);
                if (32'(r_clr_cnt) == RW - 1) begin
                    n_state = S_MARK;
                end
            end

            // mark the run's start vertex
            S_MARK: begin
                vis_we    = 1'b1;
                vis_waddr = WIW'(32'(r_a) >> BW);
                vis_wdata = WW'(1) << r_a[BW-1:0];
                n_new     = WW'(1) << r_a[BW-1:0];
                n_nbase   = WIW'(32'(r_a) >> BW);
                n_w       = WIW'(RW - 1);
                n_state   = S_DRAIN;
            end

            // label and push one newly visited vertex per cycle
            S_DRAIN: begin
                lab_we    = 1'b1;
                lab_waddr = drain_v;
                lab_wdata = (32'(r_id) > 255) ? '1 : LW'(r_id);
                stk_we    = 1'b1;
                stk_waddr = r_sp[VW-1:0];
                stk_wdata = drain_v;
                n_sp      = r_sp + CW'(1);
                n_new     = r_new & (r_new - WW'(1));
                if (n_new == '0) begin
                    if (last_word) begin
                        n_state = S_POP;
                    end else begin
                        n_w     = r_w + WIW'(1);
                        n_state = S_ARD;
                    end
                end
            end

            // pop the next vertex to expand
            S_POP: begin
                if (r_sp == '0) begin
                    n_w     = '0;
                    n_state = S_SRD;
                end else begin
                    stk_raddr = VW'(r_sp - CW'(1));
                    n_sp      = r_sp - CW'(1);
                    n_state   = S_POPW;
                end
            end

            S_POPW: begin
                n_v     = stk_rdata;
                n_w     = '0;
                n_state = S_ARD;
            end

            // fetch adjacency word and visited word
            S_ARD: begin
                adj_raddr = ADW'(32'(r_v) * RW + 32'(r_w));
                vis_raddr = r_w;
                n_state   = S_ACHK;
            end

            // newly reached vertices of this word
            S_ACHK: begin
                cand = adj_rdata & ~vis_rdata & word_mask;
                if (cand != '0) begin
                    vis_we    = 1'b1;
                    vis_waddr = r_w;
                    vis_wdata = vis_rdata | cand;
                    n_new     = cand;
                    n_nbase   = r_w;
                    n_state   = S_DRAIN;
                end else if (last_word) begin
                    n_state = S_POP;
                end else begin
                    n_w     = r_w + WIW'(1);
                    n_state = S_ARD;
                end
            end

            // search for the lowest unvisited vertex
            S_SRD: begin
                vis_raddr = r_w;
                n_state   = S_SCHK;
            end

            S_SCHK: begin
                cand = ~vis_rdata & word_mask;
                if (cand != '0) begin
                    // isolate lowest set bit as the next start
                    cand      = cand & (~cand + WW'(1));
                    vis_we    = 1'b1;
                    vis_waddr = r_w;
                    vis_wdata = vis_rdata | cand;
                    n_new     = cand;
                    n_nbase   = r_w;
                    n_w       = WIW'(RW - 1);
                    n_id      = r_id + CW'(1);
                    n_state   = S_DRAIN;
                end else if (last_word) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ccl_pkg::ST_OK;
                    n_ocid    = (32'(r_id) + 1 > 255) ? '1 : LW'(r_id + CW'(1));
                    n_olab    = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_w     = r_w + WIW'(1);
                    n_state = S_SRD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_clr_out <= 1'b0;
            r_nv      <= ccl_pkg::NUM_VERT_RESET;
            r_sp      <= '0;
            r_id      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_clr_out <= n_clr_out;
            r_sp      <= n_sp;
            r_id      <= n_id;
            r_ovalid  <= n_ovalid;
            if (psel && penable && pwrite && pready
                && paddr == ccl_pkg::ADDR_NUM_VERT) begin
                r_nv <= pwdata[ccl_pkg::NUM_VERT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_a       <= n_a;
        r_b       <= n_b;
        r_v       <= n_v;
        r_w       <= n_w;
        r_nbase   <= n_nbase;
        r_new     <= n_new;
        r_ostatus <= n_ostatus;
        r_ocid    <= n_ocid;
        r_olab    <= n_olab;
    end

    // checks
    `CCL_ASSERT(a_sp_bound, 32'(r_sp) <= MAX_VERTICES)
    `CCL_ASSERT_IMPL(a_drain_pending, r_state == S_DRAIN, r_new != '0)
    `CCL_ASSERT_NEXT(a_one_at_a_time, in_acc, !i_in.ready)
    `CCL_ASSERT_IMPL(a_err_zero, r_ovalid && r_ostatus != ccl_pkg::ST_OK,
                     r_ocid == '0 && !r_olab)
    `CCL_ASSERT_IMPL(a_query_func, r_state == S_QRY, r_func == ccl_pkg::FUNC_QUERY)

endmodule

// File: rtl/ccl_ram.sv
// ----------------------------------------------------------------------------
// Connected component labeler generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ccl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
